// ===== rtl/estr_pkg.sv =====
// Shared types and constants for the event statistics table with ranked report.
// Depends on nothing; imported by the controller, the datapath and the top level.
package estr_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned EvW    = 9;
  localparam int unsigned ElapW  = 32;
  localparam int unsigned CntW   = 48;
  localparam int unsigned CallW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_RECORD = 2'd0,
    OP_START  = 2'd1,
    OP_NEXT   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic rd;        // issue memory read at addr
    logic wr_rec;    // write back record update
    logic scan_clr;  // clear best-so-far before a scan
    logic scan_cmp;  // compare registered read data to best
    logic emit;      // load output with best entry, advance cursor/totals
    logic emit_tot;  // load output with total line
    logic start;     // reset cursor and totals, latch mode
  } dp_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic found;     // a candidate was found in the scan
    logic mode_ok;   // report mode is in range
  } dp_sts_t;

endpackage

// ===== rtl/estr_datapath.sv =====
// Datapath: statistics memories, scan compare, cursor and totals, output register.
// Depends on estr_pkg.
module estr_datapath #(
  parameter int unsigned MODES       = 4,
  parameter int unsigned EVENT_KINDS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  estr_pkg::dp_cmd_t             cmd_i,
  output estr_pkg::dp_sts_t             sts_o,
  input  logic [$clog2(MODES*EVENT_KINDS)-1:0] addr_i,
  input  logic [estr_pkg::ModeW-1:0]    mode_i,
  input  logic [estr_pkg::ElapW-1:0]    elapsed_time_i,
  input  logic                          failed_i,
  input  logic                          rd_idx_valid_i,
  input  logic [$clog2(EVENT_KINDS)-1:0] rd_idx_i,
  output logic [estr_pkg::EvW-1:0]      entry_index_o,
  output logic [estr_pkg::CntW-1:0]     call_count_o,
  output logic [estr_pkg::CntW-1:0]     time_sum_o,
  output logic [estr_pkg::CntW-1:0]     error_count_o,
  output logic                          is_total_o,
  output logic [$clog2(MODES*EVENT_KINDS)-1:0] rmode_base_o
);
  import estr_pkg::*;

  localparam int unsigned Slots = MODES * EVENT_KINDS;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned IW    = $clog2(EVENT_KINDS);
  localparam logic [CallW-1:0] MaxC = '1;
  localparam logic [CntW-1:0]  MaxT = '1;

  // memories, cleared by the controller's sweep after reset
  logic [CallW-1:0] calls_mem [Slots];
  logic [CntW-1:0]  time_mem  [Slots];
  logic [CallW-1:0] errs_mem  [Slots];

  logic [CallW-1:0] rd_calls_q;
  logic [CntW-1:0]  rd_time_q;
  logic [CallW-1:0] rd_errs_q;
  logic [AW-1:0]    wr_addr_q;
  logic [ElapW-1:0] el_q;
  logic             fail_q;

  // registered reads; latch record operands alongside
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_calls_q <= calls_mem[addr_i];
      rd_time_q  <= time_mem[addr_i];
      rd_errs_q  <= errs_mem[addr_i];
      wr_addr_q  <= addr_i;
      el_q       <= elapsed_time_i;
      fail_q     <= failed_i;
    end
  end

  // saturating record update; clear sweep writes zeros through the same port
  logic [CallW-1:0] nc, ne;
  logic [CntW-1:0]  nt;
  logic [CntW:0]    tsum;
  always_comb begin
    tsum = {1'b0, rd_time_q} + {{(CntW+1-ElapW){1'b0}}, el_q};
    nt   = tsum[CntW] ? MaxT : tsum[CntW-1:0];
    nc   = (rd_calls_q == MaxC) ? MaxC : rd_calls_q + 1'b1;
    ne   = (fail_q && rd_errs_q != MaxC) ? rd_errs_q + 1'b1 : rd_errs_q;
  end

  logic clr_w;
  assign clr_w = cmd_i.wr_rec && cmd_i.scan_clr;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_rec) begin
      calls_mem[clr_w ? addr_i : wr_addr_q] <= clr_w ? '0 : nc;
      time_mem[clr_w ? addr_i : wr_addr_q]  <= clr_w ? '0 : nt;
      errs_mem[clr_w ? addr_i : wr_addr_q]  <= clr_w ? '0 : ne;
    end
  end

  // report state
  logic [ModeW-1:0] rmode_q;
  logic             walking_q;
  logic [CntW-1:0]  cur_time_q;
  logic [IW-1:0]    cur_idx_q;
  logic [CntW-1:0]  tot_c_q, tot_t_q, tot_e_q;
  logic             found_q;
  logic [IW-1:0]    best_idx_q;
  logic [CntW-1:0]  best_time_q;
  logic [CallW-1:0] best_calls_q, best_errs_q;

  assign sts_o.found   = found_q;
  assign sts_o.mode_ok = (32'(rmode_q) < 32'(MODES));
  assign rmode_base_o  = AW'(rmode_q) * AW'(EVENT_KINDS);

  logic cand, better;
  always_comb begin
    cand = rd_idx_valid_i && (rd_calls_q != '0) &&
           (!walking_q || rd_time_q < cur_time_q ||
            (rd_time_q == cur_time_q && rd_idx_i > cur_idx_q));
    better = cand && (!found_q || rd_time_q > best_time_q);
  end

  function automatic logic [CntW-1:0] sat48(input logic [CntW-1:0] a,
                                            input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? MaxT : s[CntW-1:0];
  endfunction

  // scan, cursor and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmode_q <= '0; walking_q <= 1'b0; cur_time_q <= '0; cur_idx_q <= '0;
      tot_c_q <= '0; tot_t_q <= '0; tot_e_q <= '0; found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rmode_q <= mode_i; walking_q <= 1'b0; cur_time_q <= '0; cur_idx_q <= '0;
        tot_c_q <= '0; tot_t_q <= '0; tot_e_q <= '0;
      end
      if (cmd_i.scan_clr && !cmd_i.wr_rec) found_q <= 1'b0;
      else if (cmd_i.scan_cmp && better) found_q <= 1'b1;
      if (cmd_i.emit) begin
        walking_q  <= 1'b1;
        cur_time_q <= best_time_q;
        cur_idx_q  <= best_idx_q;
        tot_c_q    <= sat48(tot_c_q, CntW'(best_calls_q));
        tot_t_q    <= sat48(tot_t_q, best_time_q);
        tot_e_q    <= sat48(tot_e_q, CntW'(best_errs_q));
      end
    end
  end

  // best-so-far payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_cmp && better) begin
      best_idx_q   <= rd_idx_i;
      best_time_q  <= rd_time_q;
      best_calls_q <= rd_calls_q;
      best_errs_q  <= rd_errs_q;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      entry_index_o <= EvW'(best_idx_q);
      call_count_o  <= CntW'(best_calls_q);
      time_sum_o    <= best_time_q;
      error_count_o <= CntW'(best_errs_q);
      is_total_o    <= 1'b0;
    end else if (cmd_i.emit_tot) begin
      entry_index_o <= '0;
      call_count_o  <= tot_c_q;
      time_sum_o    <= tot_t_q;
      error_count_o <= tot_e_q;
      is_total_o    <= 1'b1;
    end
  end

endmodule

// ===== rtl/estr_ctrl.sv =====
// Controller: clear sweep, handshakes, record and report-scan sequencing.
// Depends on estr_pkg.
module estr_ctrl #(
  parameter int unsigned MODES       = 4,
  parameter int unsigned EVENT_KINDS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [estr_pkg::OpW-1:0]      operation_i,
  input  logic [estr_pkg::ModeW-1:0]    mode_i,
  input  logic [estr_pkg::EvW-1:0]      event_number_i,
  input  logic                          record_enable_q_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output estr_pkg::dp_cmd_t             cmd_o,
  input  estr_pkg::dp_sts_t             sts_i,
  output logic [$clog2(MODES*EVENT_KINDS)-1:0] addr_o,
  output logic                          rd_idx_valid_o,
  output logic [$clog2(EVENT_KINDS)-1:0] rd_idx_o,
  input  logic [$clog2(MODES*EVENT_KINDS)-1:0] rmode_base_i
);
  import estr_pkg::*;

  localparam int unsigned Slots = MODES * EVENT_KINDS;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned IW    = $clog2(EVENT_KINDS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          active_q, active_d;   // a walk is in progress
  logic          ov_q, ov_d;
  logic          pv_q;                 // previous scan read is valid
  logic [IW-1:0] pidx_q;

  logic acc, op_rec_ok;
  logic [31:0] mode_x;
  assign acc    = in_valid && !in_stall;
  assign mode_x = 32'(mode_i);
  assign op_rec_ok = record_enable_q_i && (mode_x < 32'(MODES)) &&
                     ({1'b0, event_number_i} < (EvW+1)'(EVENT_KINDS));
  assign in_stall  = (state_q != S_IDLE) || ov_q;
  assign out_valid = ov_q;
  assign rd_idx_valid_o = pv_q;
  assign rd_idx_o = pidx_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    ov_d     = ov_q && out_stall;
    cmd_o    = '0;
    addr_o   = AW'(mode_i) * AW'(EVENT_KINDS) + AW'(event_number_i);
    case (state_q)
      S_CLEAR: begin
        // sweep zeros through every slot
        addr_o = cnt_q[AW-1:0];
        cmd_o.wr_rec = 1'b1; cmd_o.scan_clr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(Slots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (op_e'(operation_i))
            OP_RECORD: if (op_rec_ok) begin
              cmd_o.rd = 1'b1; state_d = S_RMW;
            end
            OP_START: begin
              cmd_o.start = 1'b1; active_d = 1'b1;
            end
            OP_NEXT: if (active_q) begin
              cmd_o.scan_clr = 1'b1; cnt_d = '0; state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_RMW: begin
        cmd_o.wr_rec = 1'b1; state_d = S_IDLE;
      end
      S_SCAN: begin
        // read one slot a cycle, compare the one read last cycle
        addr_o = rmode_base_i + AW'(cnt_q[IW-1:0]);
        cmd_o.scan_cmp = 1'b1;
        if (!sts_i.mode_ok) begin
          state_d = S_DONE;
        end else if (cnt_q == (AW+1)'(EVENT_KINDS)) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd = 1'b1; cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.found) cmd_o.emit = 1'b1;
        else begin
          cmd_o.emit_tot = 1'b1; active_d = 1'b0;
        end
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; active_q <= 1'b0; ov_q <= 1'b0;
      pv_q <= 1'b0; pidx_q <= '0;
    end else begin
      state_q  <= state_d; cnt_q <= cnt_d; active_q <= active_d; ov_q <= ov_d;
      pv_q     <= cmd_o.rd && (state_q == S_SCAN);
      pidx_q   <= cnt_q[IW-1:0];
    end
  end

endmodule

// ===== rtl/event_stats_table_ranked_report.sv =====
// Top level of the event statistics table with ranked report walk.
// Depends on estr_pkg, estr_ctrl and estr_datapath.
//
//  channel | handshake             | payload
//  input   | in_valid / in_stall   | operation, mode, event_number, elapsed_time, failed
//  output  | out_valid / out_stall | entry_index, call_count, time_sum, error_count, is_total
//  config  | cfg_we                | cfg_wdata (record_enable)
//
// Record: read then write of one slot.
// Report next: one memory read per event number of the mode.
// After reset a clearing pass over all MODES*EVENT_KINDS slots zeroes the memories; input stalls.
// Input stalls while a result waits in the output register.
module event_stats_table_ranked_report #(
  parameter int unsigned MODES       = 4,
  parameter int unsigned EVENT_KINDS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [estr_pkg::OpW-1:0]      operation_i,
  input  logic [estr_pkg::ModeW-1:0]    mode_i,
  input  logic [estr_pkg::EvW-1:0]      event_number_i,
  input  logic [estr_pkg::ElapW-1:0]    elapsed_time_i,
  input  logic                          failed_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [estr_pkg::EvW-1:0]      entry_index_o,
  output logic [estr_pkg::CntW-1:0]     call_count_o,
  output logic [estr_pkg::CntW-1:0]     time_sum_o,
  output logic [estr_pkg::CntW-1:0]     error_count_o,
  output logic                          is_total_o
);
  import estr_pkg::*;

  localparam int unsigned AW = $clog2(MODES*EVENT_KINDS);
  localparam int unsigned IW = $clog2(EVENT_KINDS);

  logic          rec_en_q;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] addr, base;
  logic          rdv;
  logic [IW-1:0] rdi;

  // hold the enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rec_en_q <= 1'b0;
    else if (cfg_we) rec_en_q <= cfg_wdata;
  end

  estr_ctrl #(.MODES(MODES), .EVENT_KINDS(EVENT_KINDS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .operation_i, .mode_i, .event_number_i,
    .record_enable_q_i(rec_en_q), .out_valid, .out_stall, .cmd_o(cmd), .sts_i(sts),
    .addr_o(addr), .rd_idx_valid_o(rdv), .rd_idx_o(rdi), .rmode_base_i(base)
  );

  estr_datapath #(.MODES(MODES), .EVENT_KINDS(EVENT_KINDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .addr_i(addr),
    .mode_i, .elapsed_time_i, .failed_i, .rd_idx_valid_i(rdv), .rd_idx_i(rdi),
    .entry_index_o, .call_count_o, .time_sum_o, .error_count_o, .is_total_o,
    .rmode_base_o(base)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for event_stats_table_ranked_report: records, ranked report walks.
// Depends on estr_pkg and the RTL top level; holds its own table model and line checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import estr_pkg::*;

  localparam int unsigned MODES       = 4;
  localparam int unsigned EVENT_KINDS = 512;
  localparam int unsigned SLOTS       = MODES * EVENT_KINDS;
  localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAX32       = 48'h0000_FFFF_FFFF;
  localparam int unsigned DRAIN_CYC   = EVENT_KINDS + 16;

  typedef enum logic [1:0] {WALK_IDLE, WALK_STARTED, WALK_ON} walk_e;

  typedef struct packed {
    logic [EvW-1:0]  idx;
    logic [CntW-1:0] calls;
    logic [CntW-1:0] tsum;
    logic [CntW-1:0] errs;
    logic            tot;
  } report_line_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OpW-1:0]    operation_i = '0;
  logic [ModeW-1:0]  mode_i = '0;
  logic [EvW-1:0]    event_number_i = '0;
  logic [ElapW-1:0]  elapsed_time_i = '0;
  logic              failed_i = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [EvW-1:0]    entry_index_o;
  logic [CntW-1:0]   call_count_o;
  logic [CntW-1:0]   time_sum_o;
  logic [CntW-1:0]   error_count_o;
  logic              is_total_o;

  event_stats_table_ranked_report #(.MODES(MODES), .EVENT_KINDS(EVENT_KINDS)) u_top (
    .clk_i, .rst_ni, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .operation_i, .mode_i, .event_number_i, .elapsed_time_i, .failed_i,
    .out_valid, .out_stall, .entry_index_o, .call_count_o, .time_sum_o,
    .error_count_o, .is_total_o
  );

  always #4 clk_i = ~clk_i;

  // Table model and walk state
  logic [CntW-1:0] calls_mdl [SLOTS];
  logic [CntW-1:0] time_mdl  [SLOTS];
  logic [CntW-1:0] errs_mdl  [SLOTS];
  logic [CntW-1:0] cur_time, sum_calls, sum_time, sum_errs;
  int unsigned     cur_idx, walk_mode;
  walk_e           walk_state = WALK_IDLE;
  logic            rec_en = 1'b0;

  report_line_t expected_lines[$];
  int  failures = 0;
  bit  idle_on = 1'b0;
  int  items_sent = 0;

  function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [CntW-1:0] b,
                                              logic [CntW-1:0] mx);
    if (a >= mx || b > mx - a) return mx;
    return a + b;
  endfunction

  // Advance the model by one accepted beat and queue any report line it yields
  task automatic predict_item(op_e op, int unsigned md, int unsigned ev,
                              logic [ElapW-1:0] t, logic f);
    report_line_t ln;
    int unsigned  s, best;
    bit           found;
    logic [CntW-1:0] tm, best_t;
    found = 0;
    best = 0;
    best_t = '0;
    case (op)
      OP_RECORD: begin
        if (rec_en) begin
          s = md * EVENT_KINDS + ev;
          calls_mdl[s] = sat_add(calls_mdl[s], 48'd1, MAX32);
          time_mdl[s]  = sat_add(time_mdl[s], {16'd0, t}, MAX48);
          if (f) errs_mdl[s] = sat_add(errs_mdl[s], 48'd1, MAX32);
        end
      end
      OP_START: begin
        walk_mode = md;
        walk_state = WALK_STARTED;
        cur_time = '0;
        cur_idx = 0;
        sum_calls = '0;
        sum_time = '0;
        sum_errs = '0;
      end
      OP_NEXT: begin
        if (walk_state != WALK_IDLE) begin
          for (int unsigned k = 0; k < EVENT_KINDS; k++) begin
            s = walk_mode * EVENT_KINDS + k;
            tm = time_mdl[s];
            if (calls_mdl[s] == 0) continue;
            if (walk_state == WALK_ON &&
                !(tm < cur_time || (tm == cur_time && k > cur_idx))) continue;
            if (!found || tm > best_t) begin
              found = 1;
              best = k;
              best_t = tm;
            end
          end
          if (found) begin
            s = walk_mode * EVENT_KINDS + best;
            ln = '{best[EvW-1:0], calls_mdl[s], best_t, errs_mdl[s], 1'b0};
            sum_calls = sat_add(sum_calls, calls_mdl[s], MAX48);
            sum_time  = sat_add(sum_time, best_t, MAX48);
            sum_errs  = sat_add(sum_errs, errs_mdl[s], MAX48);
            cur_time = best_t;
            cur_idx = best;
            walk_state = WALK_ON;
          end else begin
            ln = '{'0, sum_calls, sum_time, sum_errs, 1'b1};
            walk_state = WALK_IDLE;
          end
          expected_lines.push_back(ln);
        end
      end
      default: ;
    endcase
  endtask

  // Drive one beat, hold it until accepted, then update the model
  task automatic send_item(op_e op, int unsigned md, int unsigned ev,
                           logic [ElapW-1:0] t, logic f);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    operation_i    <= op;
    mode_i         <= md[ModeW-1:0];
    event_number_i <= ev[EvW-1:0];
    elapsed_time_i <= t;
    failed_i       <= f;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    predict_item(op, md, ev, t, f);
  endtask

  // Drop valid, let every line arrive and the block fall quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_enable(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rec_en = v;
  endtask

  task automatic rand_record(int unsigned md);
    int unsigned ev;
    logic [ElapW-1:0] t;
    ev = ($urandom_range(0, 19) == 0) ? $urandom_range(0, EVENT_KINDS - 1)
                                      : $urandom_range(0, 11);
    t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) * 100 : $urandom;
    send_item(OP_RECORD, md, ev, t, $urandom_range(0, 1));
  endtask

  // Start a walk and step through it, with records mixed in; sometimes abandon it
  task automatic run_walk(int unsigned md, int max_lines);
    int n;
    n = 0;
    send_item(OP_START, md, $urandom_range(0, 511), $urandom, $urandom_range(0, 1));
    while (walk_state != WALK_IDLE && n < max_lines) begin
      if ($urandom_range(0, 5) == 0) rand_record($urandom_range(0, MODES - 1));
      send_item(OP_NEXT, md, $urandom_range(0, 511), $urandom, $urandom_range(0, 1));
      n++;
    end
  endtask

  // Check each accepted line against the oldest expectation
  always @(posedge clk_i) begin
    report_line_t ln;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $error("unexpected report line, entry_index %0d", entry_index_o);
        failures++;
      end else begin
        ln = expected_lines.pop_front();
        if (entry_index_o !== ln.idx) begin
          $error("entry_index expected %0d actual %0d", ln.idx, entry_index_o);
          failures++;
        end
        if (call_count_o !== ln.calls) begin
          $error("call_count expected %0d actual %0d", ln.calls, call_count_o);
          failures++;
        end
        if (time_sum_o !== ln.tsum) begin
          $error("time_sum expected %0d actual %0d", ln.tsum, time_sum_o);
          failures++;
        end
        if (error_count_o !== ln.errs) begin
          $error("error_count expected %0d actual %0d", ln.errs, error_count_o);
          failures++;
        end
        if (is_total_o !== ln.tot) begin
          $error("is_total expected %0d actual %0d", ln.tot, is_total_o);
          failures++;
        end
      end
    end
  end

  // Stall the output side in random bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Report next while idle, unused op code, records while disabled
  task automatic test_idle_ops();
    send_item(OP_NEXT, 0, 0, 0, 0);
    send_item(OP_NONE, 3, 511, 32'hFFFF_FFFF, 1);
    send_item(OP_RECORD, 1, 5, 32'd77, 1);
    write_enable(1'b1);
  endtask

  // Field extremes, equal times, restart and records during a walk, empty mode
  task automatic test_directed();
    send_item(OP_RECORD, 3, 511, 32'hFFFF_FFFF, 1);
    send_item(OP_RECORD, 3, 511, 32'hFFFF_FFFF, 0);
    send_item(OP_RECORD, 3, 0, 32'd0, 0);
    send_item(OP_RECORD, 1, 7, 32'd100, 0);
    send_item(OP_RECORD, 1, 3, 32'd100, 1);
    send_item(OP_RECORD, 1, 9, 32'd50, 1);
    send_item(OP_START, 1, 0, 0, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    send_item(OP_START, 1, 0, 0, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    send_item(OP_RECORD, 1, 9, 32'd500, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    send_item(OP_NEXT, 1, 0, 0, 0);
    run_walk(3, 10);
    run_walk(2, 10);
    send_item(OP_NEXT, 2, 0, 0, 0);
  endtask

  // Random walks and records across enable settings, quiet tail at the end
  task automatic test_random();
    int phase_items;
    for (int ph = 0; ph < 8; ph++) begin
      write_enable(ph != 3);
      idle_on = (ph < 7);
      phase_items = items_sent + 200;
      while (items_sent < phase_items) begin
        case ($urandom_range(0, 9))
          0:       send_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 3),
                             $urandom_range(0, 511), $urandom, $urandom_range(0, 1));
          1, 2:    run_walk($urandom_range(0, MODES - 1),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 60);
          default: rand_record($urandom_range(0, MODES - 1));
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ops();
    test_directed();
    test_random();
    drain();
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      calls_mdl[i] = '0;
      time_mdl[i] = '0;
      errs_mdl[i] = '0;
    end
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
